>>> hw/rtl/mhif_pkg.sv
// Shared constants, codes and request/result types of the max-heap core.
package mhif_pkg;

	// Heap store size and derived widths
	localparam int MAX_ENTRIES = 64;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int KEY_W       = 32;

	// Request modes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_FIND   = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_FOUND     = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_READ_OK   = 3'd5;
	localparam logic [2:0] ST_EMPTY     = 3'd6;

	// Configuration register indexes
	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [KEY_W-1:0] key;
		logic [CNT_W-1:0]        position;
	} req_t;

	typedef struct packed {
		logic [2:0]              status;
		logic signed [KEY_W-1:0] value;
		logic [CNT_W-1:0]        count;
	} res_t;

	// Heap store access: one write and one read address per cycle
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

>>> hw/rtl/mhif_ram.sv
// Heap key store: one write port, one read port with registered read data.
module mhif_ram
	import mhif_pkg::*;
(
	input  logic             clk,
	input  mem_req_t         mem,
	output logic [KEY_W-1:0] rdata
);

	logic [KEY_W-1:0] store_q [MAX_ENTRIES];

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (mem.we) begin
			store_q[mem.waddr] <= mem.wdata;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		rdata <= store_q[mem.raddr];
	end

endmodule

>>> hw/rtl/mhif_seq.sv
// Sequencer: linear key search, sift-up and position read over the key store.
module mhif_seq
	import mhif_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  req_t             req,
	input  logic [6:0]       capacity,
	output logic             busy,
	output logic             done,
	output res_t             rsp,
	output mem_req_t         mem,
	input  logic [KEY_W-1:0] rdata
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SEARCH   = 3'd1;
	localparam logic [2:0] S_SIFT_RD  = 3'd2;
	localparam logic [2:0] S_SIFT_CMP = 3'd3;
	localparam logic [2:0] S_READ     = 3'd4;

	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

	logic [2:0]              state_q;
	logic [1:0]              mode_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    pend_q;
	logic [CNT_W-1:0]        child_q;
	logic                    done_q;
	res_t                    res_q;

	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] parent;
	logic             pos_ok;
	logic             hit;
	logic             parent_less;

	// Effective limit is the smaller of capacity and store size
	assign limit = ({1'b0, capacity} >= {1'b0, CNT_MAX}) ? CNT_MAX : CNT_W'(capacity);

	assign parent      = child_q >> 1;
	assign pos_ok      = (req.position != '0) && (req.position <= cnt_q);
	assign hit         = pend_q && (rdata == key_q);
	assign parent_less = $signed(rdata) < key_q;

	// Drive the store: reads for search, parent fetch and position read; writes for sift-up
	always_comb begin
		mem = '0;
		case (state_q)
			S_IDLE: begin
				mem.raddr = ADDR_W'(req.position - CNT_ONE);
			end
			S_SEARCH: begin
				mem.raddr = idx_q[ADDR_W-1:0];
			end
			S_SIFT_RD: begin
				mem.raddr = ADDR_W'(parent - CNT_ONE);
				if (child_q == CNT_ONE) begin
					mem.we    = 1'b1;
					mem.waddr = '0;
					mem.wdata = key_q;
				end
			end
			S_SIFT_CMP: begin
				mem.we    = 1'b1;
				mem.waddr = ADDR_W'(child_q - CNT_ONE);
				mem.wdata = parent_less ? rdata : key_q;
			end
			default: begin
				mem = '0;
			end
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q <= req.mode;
						key_q  <= req.key;
						idx_q  <= '0;
						pend_q <= 1'b0;
						if (req.mode == MODE_READ) begin
							if (pos_ok) begin
								state_q <= S_READ;
							end else begin
								res_q  <= '{status: ST_EMPTY, value: '0, count: cnt_q};
								done_q <= 1'b1;
							end
						end else if (req.mode == MODE_INSERT && cnt_q >= limit) begin
							res_q  <= '{status: ST_FULL, value: req.key, count: cnt_q};
							done_q <= 1'b1;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					// Compare the word fetched last cycle while fetching the next
					if (hit) begin
						res_q.status <= (mode_q == MODE_INSERT) ? ST_DUPLICATE : ST_FOUND;
						res_q.value  <= key_q;
						res_q.count  <= cnt_q;
						done_q       <= 1'b1;
						pend_q       <= 1'b0;
						state_q      <= S_IDLE;
					end else if (idx_q == cnt_q) begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							if (mode_q == MODE_INSERT) begin
								cnt_q   <= cnt_q + CNT_ONE;
								child_q <= cnt_q + CNT_ONE;
								state_q <= S_SIFT_RD;
							end else begin
								res_q   <= '{status: ST_NOT_FOUND, value: key_q, count: cnt_q};
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
					end else begin
						idx_q  <= idx_q + CNT_ONE;
						pend_q <= 1'b1;
					end
				end
				S_SIFT_RD: begin
					// At the root the key has been written; otherwise wait for the parent
					if (child_q == CNT_ONE) begin
						res_q   <= '{status: ST_INSERTED, value: key_q, count: cnt_q};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SIFT_CMP;
					end
				end
				S_SIFT_CMP: begin
					// Move a smaller parent down, or drop the key into place
					if (parent_less) begin
						child_q <= parent;
						state_q <= S_SIFT_RD;
					end else begin
						res_q   <= '{status: ST_INSERTED, value: key_q, count: cnt_q};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					res_q   <= '{status: ST_READ_OK, value: $signed(rdata), count: cnt_q};
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = res_q;

endmodule

>>> hw/rtl/max_heap_insert_find_core.sv
// Top level of the max-heap core: configuration register, sequencer and key store.
//
//  channel   signals                         handshake
//  request   start, busy, req                taken when start & !busy
//  result    done, rsp                       shown for one cycle while done is high
//  config    psel, penable, pwrite, paddr,   written when psel & penable & pwrite
//            pwdata, prdata, pready          (pready always high)
//
// Read: the store word is fetched, then the result is registered. Find: a linear search that
// reads one store word a cycle until a hit or until the entry count is reached.
// Insert: as a find miss, then a parent read and a compare-and-write per level on the way up,
// and a root write when the key reaches the root; full and out-of-range read answer from idle.
// Reset clears the entry count and sets capacity to 64; store contents are not cleared.
// The result cannot be held off; a new request may be taken in the cycle it is shown.
module max_heap_insert_find_core
	import mhif_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output res_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [6:0]       capacity_q;
	mem_req_t         mem;
	logic [KEY_W-1:0] rdata;

	// Hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 7'd64;
		end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[6:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? {25'd0, capacity_q} : 32'd0;
	assign pready = 1'b1;

	mhif_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.capacity (capacity_q),
		.busy     (busy),
		.done     (done),
		.rsp      (rsp),
		.mem      (mem),
		.rdata    (rdata)
	);

	mhif_ram u_ram (
		.clk   (clk),
		.mem   (mem),
		.rdata (rdata)
	);

endmodule

>>> tb/max_heap_insert_find_core_tb.sv
// Self-checking testbench for the max-heap insert/find core: predicts and checks every result.
`timescale 1ns / 100ps

module max_heap_insert_find_core_tb;
	import mhif_pkg::*;

	localparam int          ITEMS_PER_PHASE = 237;
	localparam int          PHASES          = 8;
	localparam int          RANDOM_ITEMS    = ITEMS_PER_PHASE * PHASES;
	localparam int          QUIET_LIMIT     = 2000;
	localparam int          MAX_REPORTS     = 10;
	localparam logic [1:0]  MODE_UNUSED     = 2'd3;
	localparam logic [2:0]  CAPACITY_ADDR   = {REG_CAPACITY, 2'b00};
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	// Mirror of the heap: predicts each result and checks it on arrival
	class heap_result_checker;
		logic signed [KEY_W-1:0] heap_keys [1:MAX_ENTRIES];
		int unsigned             entry_cnt;
		logic [6:0]              capacity;
		res_t                    awaited_results [$];
		int unsigned             mismatches;

		function new();
			entry_cnt  = 0;
			capacity   = 7'd64;
			mismatches = 0;
		endfunction

		function void set_capacity(logic [6:0] value);
			capacity = value;
		endfunction

		function bit holds_key(logic signed [KEY_W-1:0] k);
			int unsigned i;
			for (i = 1; i <= entry_cnt; i++) begin
				if (heap_keys[i] == k)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		// Apply one accepted request to the mirror and queue its result
		function void note_request(req_t r);
			res_t                    want;
			int unsigned             limit_now;
			int unsigned             child;
			logic signed [KEY_W-1:0] held;
			limit_now  = (capacity < MAX_ENTRIES) ? capacity : MAX_ENTRIES;
			want.value = r.key;
			case (r.mode)
				MODE_INSERT: begin
					if (entry_cnt >= limit_now) begin
						want.status = ST_FULL;
					end else if (holds_key(r.key)) begin
						want.status = ST_DUPLICATE;
					end else begin
						entry_cnt++;
						child = entry_cnt;
						heap_keys[child] = r.key;
						// sift up while the parent is smaller
						while (child > 1 && heap_keys[child / 2] < heap_keys[child]) begin
							held                 = heap_keys[child / 2];
							heap_keys[child / 2] = heap_keys[child];
							heap_keys[child]     = held;
							child                = child / 2;
						end
						want.status = ST_INSERTED;
					end
				end
				MODE_READ: begin
					if (r.position >= 1 && r.position <= entry_cnt) begin
						want.status = ST_READ_OK;
						want.value  = heap_keys[r.position];
					end else begin
						want.status = ST_EMPTY;
						want.value  = '0;
					end
				end
				default: begin
					want.status = holds_key(r.key) ? ST_FOUND : ST_NOT_FOUND;
				end
			endcase
			want.count = entry_cnt[CNT_W-1:0];
			awaited_results.push_back(want);
		endfunction

		// Compare one result with the oldest prediction
		function void check_result(res_t got);
			res_t want;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] unexpected result: status %0d value %0d count %0d",
						$realtime, got.status, got.value, got.count);
				return;
			end
			want = awaited_results.pop_front();
			if (got.status !== want.status || got.value !== want.value ||
					got.count !== want.count) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
						$realtime, want.status, want.value, want.count,
						got.status, got.value, got.count);
			end
		endfunction
	endclass

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic        busy;
	req_t        req     = '0;
	logic        done;
	res_t        rsp;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	heap_result_checker chk = new();
	int unsigned        sender_idle_pct = 0;
	int unsigned        quiet_cycles    = 0;

	max_heap_insert_find_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	// Check results and count cycles in which nothing moves
	always @(posedge clk) begin
		if (arst_n && done)
			chk.check_result(rsp);
		if ((start && !busy) || done || (psel && penable && pwrite))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Abort a run that has stalled
	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	function automatic req_t make_request(logic [1:0] m, logic signed [KEY_W-1:0] k,
			logic [CNT_W-1:0] p);
		req_t r;
		r.mode     = m;
		r.key      = k;
		r.position = p;
		return r;
	endfunction

	// Draw a request, favouring keys already held so that duplicates and hits occur
	function automatic req_t random_request();
		req_t        r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			r.mode = MODE_INSERT;
		else if (pick < 65)
			r.mode = MODE_FIND;
		else if (pick < 90)
			r.mode = MODE_READ;
		else
			r.mode = MODE_UNUSED;
		pick = $urandom_range(0, 99);
		if (pick < 35 && chk.entry_cnt > 0) begin
			r.key = chk.heap_keys[$urandom_range(1, chk.entry_cnt)];
		end else if (pick < 55) begin
			r.key = $urandom_range(0, 16) - 8;
		end else if (pick < 65) begin
			case ($urandom_range(0, 4))
				0: r.key = KEY_MIN;
				1: r.key = KEY_MAX;
				2: r.key = '0;
				3: r.key = -1;
				default: r.key = 1;
			endcase
		end else begin
			r.key = $urandom;
		end
		if ($urandom_range(0, 99) < 70)
			r.position = CNT_W'($urandom_range(1, chk.entry_cnt + 1));
		else
			r.position = CNT_W'($urandom_range(0, 127));
		return r;
	endfunction

	// Offer one request after a random idle stretch and hold it until taken
	task automatic send_request(req_t r);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		chk.note_request(r);
	endtask

	// Hold off new requests until every outstanding result has come back
	task automatic drain_results();
		start <= 1'b0;
		while (chk.awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle
	task automatic write_register(logic [2:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		chk.set_capacity(data[6:0]);
	endtask

	initial begin
		req_t        directed [$];
		logic [6:0]  capacity_steps [PHASES];
		int unsigned ph;
		int unsigned i;
		int unsigned n;

		capacity_steps = '{7'd0, 7'd3, 7'd10, 7'd2, 7'd40, 7'd127, 7'd64, 7'd1};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty heap, extreme keys, duplicates, every mode, reads out of range
		directed.push_back(make_request(MODE_READ,   0,         7'd1));
		directed.push_back(make_request(MODE_READ,   0,         7'd0));
		directed.push_back(make_request(MODE_FIND,   0,         7'd0));
		directed.push_back(make_request(MODE_UNUSED, 5,         7'd0));
		directed.push_back(make_request(MODE_INSERT, 0,         7'd0));
		directed.push_back(make_request(MODE_INSERT, KEY_MIN,   7'd0));
		directed.push_back(make_request(MODE_INSERT, KEY_MAX,   7'd0));
		directed.push_back(make_request(MODE_INSERT, -1,        7'd0));
		directed.push_back(make_request(MODE_INSERT, 1,         7'd127));
		directed.push_back(make_request(MODE_INSERT, KEY_MAX,   7'd0));
		directed.push_back(make_request(MODE_INSERT, KEY_MIN,   7'd0));
		directed.push_back(make_request(MODE_FIND,   KEY_MIN,   7'd0));
		directed.push_back(make_request(MODE_FIND,   12345,     7'd0));
		directed.push_back(make_request(MODE_UNUSED, KEY_MAX,   7'd0));
		directed.push_back(make_request(MODE_READ,   -1,        7'd1));
		directed.push_back(make_request(MODE_READ,   0,         7'd5));
		directed.push_back(make_request(MODE_READ,   0,         7'd6));
		directed.push_back(make_request(MODE_READ,   0,         7'd0));
		directed.push_back(make_request(MODE_READ,   0,         7'd127));
		directed.push_back(make_request(MODE_READ,   0,         7'd64));
		directed.push_back(make_request(MODE_INSERT, KEY_MAX-1, 7'd0));
		directed.push_back(make_request(MODE_FIND,   -1,        7'd0));
		directed.push_back(make_request(MODE_READ,   0,         7'd2));
		sender_idle_pct = 23;
		foreach (directed[j])
			send_request(directed[j]);

		// Random phases, each under its own capacity
		for (ph = 0; ph < PHASES; ph++) begin
			drain_results();
			write_register(CAPACITY_ADDR, {25'd0, capacity_steps[ph]});
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				n = ph * ITEMS_PER_PHASE + i;
				if (n < RANDOM_ITEMS / 3)
					sender_idle_pct = 23;
				else if (n < 2 * RANDOM_ITEMS / 3)
					sender_idle_pct = 52;
				else
					sender_idle_pct = 0;
				if ($urandom_range(0, 149) == 0)
					drain_results();
				send_request(random_request());
			end
		end

		drain_results();
		repeat (100) @(posedge clk);
		if (chk.mismatches == 0 && chk.awaited_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/mhif_pkg.sv
hw/rtl/mhif_ram.sv
hw/rtl/mhif_seq.sv
hw/rtl/max_heap_insert_find_core.sv
tb/max_heap_insert_find_core_tb.sv
